### sv/bctm_pkg.sv
package bctm_pkg;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_DEC   = 6'b000010,
        ST_WR    = 6'b000100,
        ST_SCAN  = 6'b001000,
        ST_TSCAN = 6'b010000,
        ST_DONE  = 6'b100000
    } state_t;

    typedef enum logic [1:0] {
        KIND_CHARGER = 2'd0,
        KIND_CELL    = 2'd1,
        KIND_TEMP    = 2'd2,
        KIND_IGNORED = 2'd3
    } frame_kind_t;

    localparam logic [1:0] CFG_MIN_CELL_MV      = 2'd0;
    localparam logic [1:0] CFG_MAX_CELL_MV      = 2'd1;
    localparam logic [1:0] CFG_MAX_TEMP_C       = 2'd2;
    localparam logic [1:0] CFG_CHARGER_FRAME_ID = 2'd3;

    localparam logic [15:0] MIN_CELL_MV_RESET      = 16'd2800;
    localparam logic [15:0] MAX_CELL_MV_RESET      = 16'd4200;
    localparam logic [8:0]  MAX_TEMP_C_RESET       = 9'd70;
    localparam logic [31:0] CHARGER_FRAME_ID_RESET = 32'h1806E7F4;

    localparam int CELLS_PER_MODULE = 12;
    localparam int TEMPS_PER_MODULE = 2;
    localparam int CELLS_PER_PACKET = 4;

    localparam logic [27:0] ID_BASE      = 28'd300;
    localparam logic [27:0] ID_LIMIT     = 28'd460;
    localparam logic [15:0] DIV10_MUL    = 16'd205;
    localparam int          DIV10_SHIFT  = 11;
    localparam logic [7:0]  TEN          = 8'd10;
    localparam logic [8:0]  TEMP_OFFSET  = 9'd40;
    localparam logic [22:0] CHARGER_SCALE = 23'd100;

endpackage

### sv/bctm_ram.sv
module bctm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 36
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### sv/battery_can_telemetry_monitor_top.sv
// Battery CAN telemetry monitor. One received CAN frame enters per transaction on the
// s_ channel; one status result leaves per frame on the m_ channel. Configuration
// registers are written through cfg_we, cfg_index and cfg_data; the user must write
// them only while the block is idle, since the block itself does not enforce it.
// A frame is handled by a small sequencer: a decode state, a write state that stores
// four cell words for cell voltage frames, a walk over all stored cells through the
// cell memory read port and over all stored temperatures, all checked by one shared
// window comparator, then a done state that loads the output register. The block
// returns to idle and accepts the next frame only once the result is loaded, so it
// takes no new frame while one is still in progress.
// The output register holds a finished result while the receiver stalls, and the next
// frame is taken and processed meanwhile; only its final load waits for the register
// to be free. Reset clears the cell valid bits, so unwritten cells read as zero, and
// clears temperatures and charger values to zero, so the fault flag reads one until
// every cell holds an in-window voltage, and it returns the configuration registers
// to their defaults.
module battery_can_telemetry_monitor_top
    import bctm_pkg::*;
#(
    parameter int NUM_MODULES = 3
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // Fields from bit 0: frame_id[31:0], byte0 .. byte7.
    input  logic [95:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // Fields from bit 0: frame_kind[1:0], module_index[3:0], any_fault,
    // charger_voltage[22:0], charger_current[22:0], charger_flags[7:0], zero fill.
    output logic [63:0] m_tdata,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    localparam int NC  = CELLS_PER_MODULE * NUM_MODULES;
    localparam int NT  = TEMPS_PER_MODULE * NUM_MODULES;
    localparam int CAW = $clog2(NC);
    localparam int TAW = $clog2(NT);
    localparam int CW  = $clog2(NC + 1);

    state_t state_reg, state_next;

    logic [15:0] min_cell_mv_reg;
    logic [15:0] max_cell_mv_reg;
    logic [8:0]  max_temp_c_reg;
    logic [31:0] charger_frame_id_reg;

    logic [31:0] id_reg;
    logic [7:0]  byte_reg [8];

    logic [CW-1:0]  cnt_reg;
    logic [1:0]     kind_reg;
    logic [3:0]     module_reg;
    logic           cell_frm_reg;
    logic [CAW-1:0] cell_base_reg;
    logic           fault_reg;
    logic [NC-1:0]  cell_vld_reg;
    logic           vld_rd_reg;
    logic [8:0]     temp_store_reg [NT];

    logic [22:0] charger_voltage_reg;
    logic [22:0] charger_current_reg;
    logic [7:0]  charger_flags_reg;

    logic        m_tvalid_reg;
    logic [63:0] m_tdata_reg;

    // Frame decode from the latched id.
    logic [27:0] idm;
    logic        in_rng;
    logic [7:0]  off;
    logic [15:0] quot;
    logic [3:0]  mod_n;
    logic [7:0]  rem;
    logic [7:0]  pkt_m;
    logic        mod_ok;
    logic        is_cell;
    logic        is_temp;
    logic        chg_hit;
    logic [7:0]  base_wide;
    logic [TAW-1:0] tidx;

    assign idm     = id_reg[27:0];
    assign in_rng  = (idm > ID_BASE) && (idm < ID_LIMIT);
    assign off     = 8'(idm - ID_BASE);
    assign quot    = 16'(off) * DIV10_MUL;
    assign mod_n   = quot[DIV10_SHIFT+3:DIV10_SHIFT];
    assign rem     = off - 8'(8'(mod_n) * TEN);
    assign pkt_m   = rem - 8'd1;
    assign mod_ok  = in_rng && (rem != 8'd0) && ({1'b0, mod_n} < 5'(NUM_MODULES));
    assign is_cell = mod_ok && (pkt_m < 8'd3);
    assign is_temp = mod_ok && (pkt_m == 8'd3);
    assign chg_hit = (id_reg == charger_frame_id_reg);
    assign base_wide = 8'(8'(mod_n) * 8'(CELLS_PER_MODULE)) + {4'd0, pkt_m[1:0], 2'b00};
    assign tidx    = TAW'({mod_n, 1'b0});

    // Cell memory access.
    logic           ram_we;
    logic [CAW-1:0] ram_waddr;
    logic [15:0]    ram_wdata;
    logic [CAW-1:0] ram_raddr;
    logic [15:0]    ram_rdata;
    logic [2:0]     hi_sel;
    logic [2:0]     lo_sel;

    assign hi_sel    = {cnt_reg[1:0], 1'b0};
    assign lo_sel    = {cnt_reg[1:0], 1'b1};
    assign ram_we    = (state_reg == ST_WR);
    assign ram_waddr = cell_base_reg + CAW'(cnt_reg[1:0]);
    assign ram_wdata = {byte_reg[hi_sel], byte_reg[lo_sel]};
    assign ram_raddr = (cnt_reg < CW'(NC)) ? cnt_reg[CAW-1:0] : '0;

    bctm_ram #(
        .WIDTH(16),
        .DEPTH(NC)
    ) u_cell_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Shared window comparator for cells and temperatures.
    logic               cmp_en;
    logic signed [16:0] cmp_val;
    logic signed [16:0] cmp_lo;
    logic signed [16:0] cmp_hi;
    logic               cmp_out;
    logic [8:0]         temp_rd;

    assign temp_rd = temp_store_reg[cnt_reg[TAW-1:0]];

    always_comb
    begin
        cmp_en  = 1'b0;
        cmp_val = '0;
        cmp_lo  = '0;
        cmp_hi  = '0;
        case (state_reg)
            ST_SCAN:
            begin
                cmp_en  = (cnt_reg != '0);
                cmp_val = vld_rd_reg ? $signed({1'b0, ram_rdata}) : '0;
                cmp_lo  = $signed({1'b0, min_cell_mv_reg});
                cmp_hi  = $signed({1'b0, max_cell_mv_reg});
            end
            ST_TSCAN:
            begin
                cmp_en  = 1'b1;
                cmp_val = $signed({{8{temp_rd[8]}}, temp_rd});
                cmp_lo  = $signed({{8{1'b1}}, 9'h100});
                cmp_hi  = $signed({{8{max_temp_c_reg[8]}}, max_temp_c_reg});
            end
            default:
            begin
                cmp_en = 1'b0;
            end
        endcase
    end

    assign cmp_out = cmp_en && ((cmp_val < cmp_lo) || (cmp_val > cmp_hi));

    logic out_free;
    assign out_free = !m_tvalid_reg || m_tready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = ST_DEC;
                end
            end
            ST_DEC:
            begin
                state_next = is_cell ? ST_WR : ST_SCAN;
            end
            ST_WR:
            begin
                if (cnt_reg[1:0] == 2'd3)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (cnt_reg == CW'(NC))
                begin
                    state_next = ST_TSCAN;
                end
            end
            ST_TSCAN:
            begin
                if (cnt_reg == CW'(NT - 1))
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg            <= ST_IDLE;
            min_cell_mv_reg      <= MIN_CELL_MV_RESET;
            max_cell_mv_reg      <= MAX_CELL_MV_RESET;
            max_temp_c_reg       <= MAX_TEMP_C_RESET;
            charger_frame_id_reg <= CHARGER_FRAME_ID_RESET;
            cnt_reg              <= '0;
            kind_reg             <= KIND_IGNORED;
            module_reg           <= '0;
            cell_frm_reg         <= 1'b0;
            cell_base_reg        <= '0;
            fault_reg            <= 1'b0;
            cell_vld_reg         <= '0;
            vld_rd_reg           <= 1'b0;
            charger_voltage_reg  <= '0;
            charger_current_reg  <= '0;
            charger_flags_reg    <= '0;
            m_tvalid_reg         <= 1'b0;
            for (int j = 0; j < NT; j++)
            begin
                temp_store_reg[j] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_MIN_CELL_MV:      min_cell_mv_reg      <= cfg_data[15:0];
                    CFG_MAX_CELL_MV:      max_cell_mv_reg      <= cfg_data[15:0];
                    CFG_MAX_TEMP_C:       max_temp_c_reg       <= cfg_data[8:0];
                    CFG_CHARGER_FRAME_ID: charger_frame_id_reg <= cfg_data;
                    default:              min_cell_mv_reg      <= min_cell_mv_reg;
                endcase
            end

            vld_rd_reg <= cell_vld_reg[ram_raddr];

            case (state_reg)
                ST_DEC:
                begin
                    cnt_reg       <= '0;
                    fault_reg     <= 1'b0;
                    cell_frm_reg  <= is_cell;
                    cell_base_reg <= CAW'(base_wide);
                    module_reg    <= (is_cell || is_temp) ? mod_n : 4'd0;
                    if (chg_hit)
                    begin
                        kind_reg            <= KIND_CHARGER;
                        charger_voltage_reg <= 23'({byte_reg[0], byte_reg[1]}) * CHARGER_SCALE;
                        charger_current_reg <= 23'({byte_reg[2], byte_reg[3]}) * CHARGER_SCALE;
                        charger_flags_reg   <= byte_reg[4];
                    end
                    else if (is_cell)
                    begin
                        kind_reg <= KIND_CELL;
                    end
                    else if (is_temp)
                    begin
                        kind_reg <= KIND_TEMP;
                    end
                    else
                    begin
                        kind_reg <= KIND_IGNORED;
                    end
                    if (is_temp)
                    begin
                        temp_store_reg[tidx]         <= {1'b0, byte_reg[0]} - TEMP_OFFSET;
                        temp_store_reg[tidx + 1'b1]  <= {1'b0, byte_reg[1]} - TEMP_OFFSET;
                    end
                end
                ST_WR:
                begin
                    cell_vld_reg[ram_waddr] <= 1'b1;
                    cnt_reg <= (cnt_reg[1:0] == 2'd3) ? '0 : cnt_reg + 1'b1;
                end
                ST_SCAN:
                begin
                    fault_reg <= fault_reg | cmp_out;
                    cnt_reg   <= (cnt_reg == CW'(NC)) ? '0 : cnt_reg + 1'b1;
                end
                ST_TSCAN:
                begin
                    fault_reg <= fault_reg | cmp_out;
                    cnt_reg   <= cnt_reg + 1'b1;
                end
                default:
                begin
                    cnt_reg <= cnt_reg;
                end
            endcase

            if ((state_reg == ST_DONE) && out_free)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            id_reg <= s_tdata[31:0];
            for (int b = 0; b < 8; b++)
            begin
                byte_reg[b] <= s_tdata[32 + 8*b +: 8];
            end
        end
        if ((state_reg == ST_DONE) && out_free)
        begin
            m_tdata_reg <= {3'd0, charger_flags_reg, charger_current_reg,
                            charger_voltage_reg, fault_reg, module_reg, kind_reg};
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    a_accept_to_decode: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> state_reg == ST_DEC)
        else $error("accepted frame did not enter decode");

    a_load_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result loaded outside the done state");

    a_write_only_cells: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_WR |-> cell_frm_reg)
        else $error("cell memory written for a frame that carries no cells");

    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SCAN |-> cnt_reg <= CW'(NC))
        else $error("cell walk ran past the store");

endmodule
